>>> rtl/hngp_pkg.sv
// ----------------------------------------------------------------------------
// hngp_pkg
// Shared types, codes, constants and hash functions of the hashed n-gram
// byte predictor.
// ----------------------------------------------------------------------------
package hngp_pkg;

    localparam int CTX_BITS_DEF = 12;
    localparam int SLOTS_DEF    = 8;

    localparam int PAIR_DEPTH = 65536;
    localparam int PAIR_AW    = 16;

    localparam logic [31:0] HASH7_SEED = 32'hA55AA55A;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;
    localparam logic [7:0]  NO_TOKEN   = 8'd32;
    localparam logic [8:0]  BIGRAM_LEN = 9'd256;

    // model_kind codes
    localparam logic [2:0] KIND_BIGRAM  = 3'd0;
    localparam logic [2:0] KIND_TRI     = 3'd1;
    localparam logic [2:0] KIND_FOUR    = 3'd2;
    localparam logic [2:0] KIND_OCTA    = 3'd3;
    localparam logic [2:0] KIND_CASCADE = 3'd4;

    // command codes; the spare code acts as a query
    localparam logic [1:0] CMD_LEARN = 2'd0;
    localparam logic [1:0] CMD_SHIFT = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_SLOTS = 2'd1;
    localparam logic [1:0] CFG_CTXB  = 2'd2;

    typedef enum logic [1:0] {
        SRC_O2,
        SRC_O3,
        SRC_O7,
        SRC_BI
    } src_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PSTART,
        ST_PSCAN,
        ST_PCHECK,
        ST_DIV,
        ST_PAIR_RD,
        ST_PAIR_WR,
        ST_LSTART,
        ST_LSCAN,
        ST_LWR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic scan_start;
        logic learn_mode;
        src_t src;
        logic take_pred;
        logic pair_rd;
        logic pair_wr;
        logic learn_wr;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic       scan_done;
        logic       total_nz;
        logic       div_done;
        logic       out_free;
        logic       is_learn;
        logic [2:0] kind;
    } dp_stat_t;

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    endfunction

    function automatic logic [31:0] hash2(logic [7:0] h1, logic [7:0] h0);
        logic [31:0] h;
        h = {16'h0, h1, h0};
        h = h ^ (h << 7);
        h = h ^ (h >> 3);
        h = h ^ (h << 11);
        return h;
    endfunction

    function automatic logic [31:0] hash3(logic [7:0] h2, logic [7:0] h1, logic [7:0] h0);
        logic [31:0] h;
        h = {8'h0, h2, h1, h0};
        h = h ^ (h << 5);
        h = h ^ (h >> 7);
        h = h ^ (h << 9);
        return h;
    endfunction

    function automatic logic [31:0] hash7(logic [7:0] h6, logic [7:0] h5, logic [7:0] h4,
                                          logic [7:0] h3, logic [7:0] h2, logic [7:0] h1,
                                          logic [7:0] h0);
        logic [31:0] h;
        h = HASH7_SEED ^ {h6, h5, h4, h3} ^ {h2, h1, h0, 8'h0};
        h = h ^ (h << 5);
        h = h ^ (h >> 11);
        h = h ^ (h << 13);
        return h;
    endfunction

endpackage

>>> rtl/hngp_ram.sv
// ----------------------------------------------------------------------------
// hngp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hngp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/hngp_ctrl.sv
// ----------------------------------------------------------------------------
// hngp_ctrl
// Sequencer: clearing pass, prediction cascade, divide, learning, hand-off.
// ----------------------------------------------------------------------------
module hngp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hngp_pkg::dp_stat_t stat,
    output hngp_pkg::ctl_cmd_t ctl
);

    hngp_pkg::state_t state_reg, state_next;
    hngp_pkg::src_t   src_reg, src_next;

    // first context source to try for a kind
    function automatic hngp_pkg::src_t pred_first(logic [2:0] kind);
        hngp_pkg::src_t s;
        unique case (kind) inside
            hngp_pkg::KIND_CASCADE, hngp_pkg::KIND_OCTA: s = hngp_pkg::SRC_O7;
            hngp_pkg::KIND_FOUR:                         s = hngp_pkg::SRC_O3;
            hngp_pkg::KIND_TRI:                          s = hngp_pkg::SRC_O2;
            default:                                     s = hngp_pkg::SRC_BI;
        endcase
        return s;
    endfunction

    function automatic hngp_pkg::src_t pred_next(logic [2:0] kind, hngp_pkg::src_t cur);
        hngp_pkg::src_t s;
        s = hngp_pkg::SRC_BI;
        if (kind == hngp_pkg::KIND_CASCADE)
        begin
            unique case (cur)
                hngp_pkg::SRC_O7: s = hngp_pkg::SRC_O3;
                hngp_pkg::SRC_O3: s = hngp_pkg::SRC_O2;
                default:          s = hngp_pkg::SRC_BI;
            endcase
        end
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hngp_pkg::ST_CLEAR;
            src_reg   <= hngp_pkg::SRC_BI;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        ctl        = '0;
        ctl.src    = src_reg;
        in_stall   = (state_reg != hngp_pkg::ST_IDLE);
        unique case (state_reg)
            hngp_pkg::ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = hngp_pkg::ST_IDLE;
                end
            end
            hngp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    src_next   = pred_first(stat.kind);
                    state_next = hngp_pkg::ST_PSTART;
                end
            end
            hngp_pkg::ST_PSTART:
            begin
                ctl.scan_start = 1'b1;
                state_next     = hngp_pkg::ST_PSCAN;
            end
            hngp_pkg::ST_PSCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = hngp_pkg::ST_PCHECK;
                end
            end
            hngp_pkg::ST_PCHECK:
            begin
                if (stat.total_nz || src_reg == hngp_pkg::SRC_BI)
                begin
                    ctl.take_pred = 1'b1;
                    state_next    = hngp_pkg::ST_DIV;
                end
                else
                begin
                    src_next   = pred_next(stat.kind, src_reg);
                    state_next = hngp_pkg::ST_PSTART;
                end
            end
            hngp_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.is_learn ? hngp_pkg::ST_PAIR_RD : hngp_pkg::ST_DONE;
                end
            end
            hngp_pkg::ST_PAIR_RD:
            begin
                ctl.pair_rd = 1'b1;
                state_next  = hngp_pkg::ST_PAIR_WR;
            end
            hngp_pkg::ST_PAIR_WR:
            begin
                ctl.pair_wr = 1'b1;
                if (stat.kind >= hngp_pkg::KIND_TRI)
                begin
                    src_next   = hngp_pkg::SRC_O2;
                    state_next = hngp_pkg::ST_LSTART;
                end
                else
                begin
                    state_next = hngp_pkg::ST_DONE;
                end
            end
            hngp_pkg::ST_LSTART:
            begin
                ctl.scan_start = 1'b1;
                ctl.learn_mode = 1'b1;
                state_next     = hngp_pkg::ST_LSCAN;
            end
            hngp_pkg::ST_LSCAN:
            begin
                ctl.learn_mode = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = hngp_pkg::ST_LWR;
                end
            end
            hngp_pkg::ST_LWR:
            begin
                ctl.learn_wr = 1'b1;
                state_next   = hngp_pkg::ST_DONE;
                if (src_reg == hngp_pkg::SRC_O2 && stat.kind >= hngp_pkg::KIND_FOUR)
                begin
                    src_next   = hngp_pkg::SRC_O3;
                    state_next = hngp_pkg::ST_LSTART;
                end
                else if (src_reg == hngp_pkg::SRC_O3 && stat.kind >= hngp_pkg::KIND_OCTA)
                begin
                    src_next   = hngp_pkg::SRC_O7;
                    state_next = hngp_pkg::ST_LSTART;
                end
            end
            hngp_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = hngp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hngp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/hngp_dp.sv
// ----------------------------------------------------------------------------
// hngp_dp
// Datapath: configuration, history, hashed bucket tables, bigram counts,
// slot scan, confidence divider and output register.
// ----------------------------------------------------------------------------
module hngp_dp #(
    parameter int CTX_BITS = hngp_pkg::CTX_BITS_DEF,
    parameter int SLOTS    = hngp_pkg::SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic [1:0]         cmd,
    input  logic [7:0]         byte_in,
    input  logic               out_stall,
    input  hngp_pkg::ctl_cmd_t ctl,
    output hngp_pkg::dp_stat_t stat,
    output logic               out_valid,
    output logic [7:0]         pred_token,
    output logic [7:0]         confidence,
    output logic               hit
);

    localparam int TBL_DEPTH = (1 << CTX_BITS) * SLOTS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CLR_LEN   = (TBL_DEPTH > hngp_pkg::PAIR_DEPTH) ? TBL_DEPTH
                                                                  : hngp_pkg::PAIR_DEPTH;
    localparam int CLR_W     = $clog2(CLR_LEN);
    localparam int SI_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int N_W       = $clog2(SLOTS + 1);

    // configuration
    logic [2:0] kind_reg;
    logic [3:0] slots_reg;
    logic [3:0] ctxb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= hngp_pkg::KIND_CASCADE;
            slots_reg <= 4'd8;
            ctxb_reg  <= 4'd12;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hngp_pkg::CFG_KIND:  kind_reg  <= cfg_data[2:0];
                hngp_pkg::CFG_SLOTS: slots_reg <= cfg_data;
                hngp_pkg::CFG_CTXB:  ctxb_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    logic [2:0]          kind_eff;
    logic [N_W-1:0]      n_eff;
    logic [4:0]          bits_eff;
    logic [CTX_BITS-1:0] mask;

    assign kind_eff = (kind_reg > hngp_pkg::KIND_CASCADE) ? hngp_pkg::KIND_CASCADE : kind_reg;

    always_comb
    begin
        if (slots_reg == 4'd0)
        begin
            n_eff = N_W'(1);
        end
        else if ({1'b0, slots_reg} > 5'(SLOTS))
        begin
            n_eff = N_W'(SLOTS);
        end
        else
        begin
            n_eff = N_W'(slots_reg);
        end
        bits_eff = ({1'b0, ctxb_reg} > 5'(CTX_BITS)) ? 5'(CTX_BITS) : {1'b0, ctxb_reg};
        for (int i = 0; i < CTX_BITS; i++)
        begin
            mask[i] = (i < int'(bits_eff));
        end
    end

    // history and item
    logic [7:0] hist_reg [7];
    logic [1:0] cmd_reg;
    logic [7:0] byte_reg;
    logic       is_learn;
    logic       is_shift;

    assign is_learn = (cmd_reg == hngp_pkg::CMD_LEARN);
    assign is_shift = (cmd_reg == hngp_pkg::CMD_LEARN) || (cmd_reg == hngp_pkg::CMD_SHIFT);

    logic [31:0]         h2_full, h3_full, h7_full;
    logic [CTX_BITS-1:0] bkt2, bkt3, bkt7;
    logic [TBL_AW-1:0]   base2_reg, base3_reg, base7_reg;

    assign h2_full = hngp_pkg::hash2(hist_reg[1], hist_reg[0]);
    assign h3_full = hngp_pkg::hash3(hist_reg[2], hist_reg[1], hist_reg[0]);
    assign h7_full = hngp_pkg::hash7(hist_reg[6], hist_reg[5], hist_reg[4], hist_reg[3],
                                     hist_reg[2], hist_reg[1], hist_reg[0]);
    assign bkt2 = h2_full[CTX_BITS-1:0] & mask;
    assign bkt3 = h3_full[CTX_BITS-1:0] & mask;
    assign bkt7 = h7_full[CTX_BITS-1:0] & mask;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= cmd;
            byte_reg  <= byte_in;
            base2_reg <= TBL_AW'(bkt2) * TBL_AW'(SLOTS);
            base3_reg <= TBL_AW'(bkt3) * TBL_AW'(SLOTS);
            base7_reg <= TBL_AW'(bkt7) * TBL_AW'(SLOTS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                hist_reg[i] <= 8'd0;
            end
        end
        else if (ctl.finish && is_shift)
        begin
            for (int i = 6; i > 0; i--)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0] <= byte_reg;
        end
    end

    // clearing pass
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clr_tbl;
    logic             clr_pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clr_step && !stat.clear_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
        end
    end

    assign clr_tbl  = ctl.clr_step && ({1'b0, clr_cnt_reg} < (CLR_W+1)'(TBL_DEPTH));
    assign clr_pair = ctl.clr_step && ({1'b0, clr_cnt_reg} < (CLR_W+1)'(hngp_pkg::PAIR_DEPTH));

    // slot scan
    logic            scan_active_reg;
    logic [8:0]      issue_reg;
    logic            rd_vld_reg;
    logic [8:0]      rd_idx_reg;
    logic            mode_reg;
    logic [8:0]      scan_len;
    logic [SI_W-1:0] issue_slot;

    assign scan_len   = (ctl.src == hngp_pkg::SRC_BI) ? hngp_pkg::BIGRAM_LEN : 9'(n_eff);
    assign issue_slot = issue_reg[SI_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_active_reg <= 1'b0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= 9'd0;
            issue_reg       <= 9'd0;
            mode_reg        <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= scan_active_reg;
            rd_idx_reg <= issue_reg;
            if (ctl.scan_start)
            begin
                scan_active_reg <= 1'b1;
                issue_reg       <= 9'd0;
                mode_reg        <= ctl.learn_mode;
            end
            else if (scan_active_reg)
            begin
                issue_reg <= issue_reg + 9'd1;
                if (issue_reg == scan_len - 9'd1)
                begin
                    scan_active_reg <= 1'b0;
                end
            end
        end
    end

    // memories
    logic [23:0]       o2_rdata, o3_rdata, o7_rdata;
    logic [15:0]       pair_rdata;
    logic [TBL_AW-1:0] o2_raddr, o3_raddr, o7_raddr;
    logic [TBL_AW-1:0] base_sel;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [23:0]       tbl_wdata;
    logic [SI_W-1:0]   wr_slot;
    logic [7:0]        wr_tok;
    logic [15:0]       wr_cnt;
    logic              o2_we, o3_we, o7_we, pair_we;
    logic [15:0]       pair_waddr, pair_raddr, pair_wdata;

    assign o2_raddr = base2_reg + TBL_AW'(issue_slot);
    assign o3_raddr = base3_reg + TBL_AW'(issue_slot);
    assign o7_raddr = base7_reg + TBL_AW'(issue_slot);

    always_comb
    begin
        case (ctl.src)
            hngp_pkg::SRC_O2: base_sel = base2_reg;
            hngp_pkg::SRC_O3: base_sel = base3_reg;
            default:          base_sel = base7_reg;
        endcase
    end

    // learn scan results
    logic            found_reg, free_reg;
    logic [SI_W-1:0] found_i_reg, free_i_reg, min_i_reg;
    logic [15:0]     found_c_reg, min_c_reg;
    logic [7:0]      min_tok_reg;

    // pick the slot to rewrite: match, free slot, or the minimum
    always_comb
    begin
        if (found_reg)
        begin
            wr_slot = found_i_reg;
            wr_tok  = byte_reg;
            wr_cnt  = hngp_pkg::sat_inc(found_c_reg);
        end
        else if (free_reg)
        begin
            wr_slot = free_i_reg;
            wr_tok  = byte_reg;
            wr_cnt  = 16'd1;
        end
        else if (min_c_reg > 16'd1)
        begin
            wr_slot = min_i_reg;
            wr_tok  = min_tok_reg;
            wr_cnt  = min_c_reg - 16'd1;
        end
        else
        begin
            wr_slot = min_i_reg;
            wr_tok  = byte_reg;
            wr_cnt  = 16'd1;
        end
    end

    assign tbl_waddr = ctl.clr_step ? clr_cnt_reg[TBL_AW-1:0] : base_sel + TBL_AW'(wr_slot);
    assign tbl_wdata = ctl.clr_step ? 24'd0 : {wr_tok, wr_cnt};
    assign o2_we = clr_tbl || (ctl.learn_wr && ctl.src == hngp_pkg::SRC_O2);
    assign o3_we = clr_tbl || (ctl.learn_wr && ctl.src == hngp_pkg::SRC_O3);
    assign o7_we = clr_tbl || (ctl.learn_wr && ctl.src == hngp_pkg::SRC_O7);

    assign pair_raddr = ctl.pair_rd ? {hist_reg[0], byte_reg} : {hist_reg[0], issue_reg[7:0]};
    assign pair_waddr = ctl.clr_step ? clr_cnt_reg[hngp_pkg::PAIR_AW-1:0]
                                     : {hist_reg[0], byte_reg};
    assign pair_wdata = ctl.clr_step ? 16'd0 : hngp_pkg::sat_inc(pair_rdata);
    assign pair_we    = clr_pair || ctl.pair_wr;

    hngp_ram #(.WIDTH(24), .DEPTH(TBL_DEPTH)) u_o2_ram (
        .clk   (clk),
        .we    (o2_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (o2_raddr),
        .rdata (o2_rdata)
    );

    hngp_ram #(.WIDTH(24), .DEPTH(TBL_DEPTH)) u_o3_ram (
        .clk   (clk),
        .we    (o3_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (o3_raddr),
        .rdata (o3_rdata)
    );

    hngp_ram #(.WIDTH(24), .DEPTH(TBL_DEPTH)) u_o7_ram (
        .clk   (clk),
        .we    (o7_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (o7_raddr),
        .rdata (o7_rdata)
    );

    hngp_ram #(.WIDTH(16), .DEPTH(hngp_pkg::PAIR_DEPTH)) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rdata)
    );

    // returned slot
    logic [7:0]      sl_tok;
    logic [15:0]     sl_cnt;
    logic [SI_W-1:0] rd_slot;

    assign rd_slot = rd_idx_reg[SI_W-1:0];

    always_comb
    begin
        case (ctl.src)
            hngp_pkg::SRC_O2: {sl_tok, sl_cnt} = o2_rdata;
            hngp_pkg::SRC_O3: {sl_tok, sl_cnt} = o3_rdata;
            hngp_pkg::SRC_O7: {sl_tok, sl_cnt} = o7_rdata;
            default:          {sl_tok, sl_cnt} = {rd_idx_reg[7:0], pair_rdata};
        endcase
    end

    logic [23:0] total_reg;
    logic [15:0] best_reg;
    logic [7:0]  btok_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.scan_start)
        begin
            total_reg <= 24'd0;
            best_reg  <= 16'd0;
            btok_reg  <= hngp_pkg::NO_TOKEN;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (rd_vld_reg && !mode_reg)
        begin
            total_reg <= total_reg + 24'(sl_cnt);
            if (sl_cnt > best_reg)
            begin
                best_reg <= sl_cnt;
                btok_reg <= sl_tok;
            end
        end
        else if (rd_vld_reg && !found_reg)
        begin
            if (sl_cnt == 16'd0 && !free_reg)
            begin
                free_reg   <= 1'b1;
                free_i_reg <= rd_slot;
            end
            if (sl_cnt != 16'd0 && sl_tok == byte_reg)
            begin
                found_reg   <= 1'b1;
                found_i_reg <= rd_slot;
                found_c_reg <= sl_cnt;
            end
            // first strict minimum, seeded by slot zero
            if (rd_idx_reg == 9'd0 || sl_cnt < min_c_reg)
            begin
                min_c_reg   <= sl_cnt;
                min_i_reg   <= rd_slot;
                min_tok_reg <= sl_tok;
            end
        end
    end

    // confidence divider: best*255/total, quotient never above 255
    logic        div_busy_reg;
    logic [2:0]  div_k_reg;
    logic [23:0] rem_reg;
    logic [23:0] dsr_reg;
    logic [7:0]  q_reg;
    logic [7:0]  res_tok_reg;
    logic [31:0] dsr_shift;

    assign dsr_shift = {8'd0, dsr_reg} << div_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
        end
        else if (ctl.take_pred)
        begin
            div_busy_reg <= (total_reg != 24'd0);
        end
        else if (div_busy_reg && div_k_reg == 3'd0)
        begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_pred)
        begin
            res_tok_reg <= btok_reg;
            rem_reg     <= {best_reg, 8'd0} - 24'(best_reg);
            dsr_reg     <= total_reg;
            div_k_reg   <= 3'd7;
            q_reg       <= 8'd0;
        end
        else if (div_busy_reg)
        begin
            if ({8'd0, rem_reg} >= dsr_shift)
            begin
                rem_reg          <= rem_reg - dsr_shift[23:0];
                q_reg[div_k_reg] <= 1'b1;
            end
            div_k_reg <= div_k_reg - 3'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (ctl.finish)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            pred_token <= res_tok_reg;
            confidence <= q_reg;
            hit        <= is_shift && (res_tok_reg == byte_reg);
        end
    end

    always_comb
    begin
        stat.clear_done = (clr_cnt_reg == CLR_W'(CLR_LEN - 1));
        stat.scan_done  = !scan_active_reg && !rd_vld_reg;
        stat.total_nz   = (total_reg != 24'd0);
        stat.div_done   = !div_busy_reg;
        stat.out_free   = !out_valid || !out_stall;
        stat.is_learn   = is_learn;
        stat.kind       = kind_eff;
    end

endmodule

>>> rtl/hashed_ngram_byte_predictor.sv
// ----------------------------------------------------------------------------
// hashed_ngram_byte_predictor
// Online byte predictor from hashed order-7/3/2 contexts with bigram fallback.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries a command and a byte and
// yields one result: the byte predicted from the history before it, a
// confidence of best*255/total, and a hit flag. After reset the block runs a
// clearing pass over every entry of its tables and accepts no transaction
// meanwhile; config writes are taken at any time. An item scans the bucket
// of each context searched for its kind, and the bigram row when it
// falls back to it, then runs the divider (skipped when the total count is
// zero); a learn command then bumps the bigram count and trains each
// hashed table that its kind uses, where a bucket scan reads n slots and n
// is the effective slots_in_use. A stalled result holds back the finish of
// the next item. The slot and row scans read the registered-read table RAMs
// one entry per cycle. One item is in work at a time; a finished result
// waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module hashed_ngram_byte_predictor #(
    parameter int CTX_BITS = hngp_pkg::CTX_BITS_DEF,
    parameter int SLOTS    = hngp_pkg::SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] byte_in,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] pred_token,
    output logic [7:0] confidence,
    output logic       hit
);

    hngp_pkg::ctl_cmd_t ctl;
    hngp_pkg::dp_stat_t stat;

    // sequence the clearing pass, the cascade, the divide and the learn steps
    hngp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // hold tables, history, scan accumulators and the result register
    hngp_dp #(
        .CTX_BITS (CTX_BITS),
        .SLOTS    (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .byte_in    (byte_in),
        .out_stall  (out_stall),
        .ctl        (ctl),
        .stat       (stat),
        .out_valid  (out_valid),
        .pred_token (pred_token),
        .confidence (confidence),
        .hit        (hit)
    );

endmodule
